// ----- sv/dts_pkg.sv -----
// Shared constants and types for the dwell time selection trigger.
package dts_pkg;

    localparam int TS_W       = 32;
    localparam int DWELL_W    = 16;
    localparam int CELL_W     = 4;
    localparam int GRID_DIM   = 16;
    localparam int PROG_FRAC  = 10;
    localparam int PROG_W     = PROG_FRAC + 1;
    localparam int MODE_W     = 2;

    localparam int DIGIT_W    = 2;
    localparam int SUB_STEPS  = TS_W / DIGIT_W;
    localparam int SUB_CNT_W  = $clog2(SUB_STEPS);
    localparam int DIV_STEPS  = PROG_FRAC;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [DWELL_W-1:0] DWELL_RESET = DWELL_W'(600);
    localparam logic [PROG_W-1:0]  PROG_FULL   = PROG_W'(1) << PROG_FRAC;
    localparam logic [PROG_W-1:0]  PROG_ZERO   = '0;

    localparam logic [MODE_W-1:0] MODE_OPEN     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PRESSED  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASED = 2'd2;
    localparam logic [MODE_W-1:0] MODE_HOLD     = 2'd3;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_REARM = 1'b1;

    typedef struct packed {
        logic            done;
        logic [TS_W-1:0] diff;
    } sub_res_t;

    typedef struct packed {
        logic              done;
        logic [PROG_W-1:0] quot;
    } div_res_t;

endpackage

// ----- sv/dts_ser_sub.sv -----
// Digit-serial 32-bit subtractor, two bits per cycle, LSB first.
module dts_ser_sub (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [dts_pkg::TS_W-1:0] a,
    input  logic [dts_pkg::TS_W-1:0] b,
    output dts_pkg::sub_res_t     res
);
    import dts_pkg::*;

    logic [TS_W-1:0]      a_sh_reg;
    logic [TS_W-1:0]      b_sh_reg;
    logic [TS_W-1:0]      d_sh_reg;
    logic                 borrow_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [SUB_CNT_W-1:0] cnt_reg;
    logic [DIGIT_W:0]     dig;

    assign dig = {1'b0, a_sh_reg[DIGIT_W-1:0]} - {1'b0, b_sh_reg[DIGIT_W-1:0]}
                 - {{DIGIT_W{1'b0}}, borrow_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == SUB_CNT_W'(SUB_STEPS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == SUB_CNT_W'(SUB_STEPS - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_sh_reg   <= a;
            b_sh_reg   <= b;
            borrow_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            a_sh_reg   <= a_sh_reg >> DIGIT_W;
            b_sh_reg   <= b_sh_reg >> DIGIT_W;
            d_sh_reg   <= {dig[DIGIT_W-1:0], d_sh_reg[TS_W-1:DIGIT_W]};
            borrow_reg <= dig[DIGIT_W];
        end
    end

    assign res.done = done_reg;
    assign res.diff = d_sh_reg;

endmodule

// ----- sv/dts_div.sv -----
// Restoring divider for Q1.10 progress, one quotient bit per cycle.
module dts_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [dts_pkg::DWELL_W-1:0] num,
    input  logic [dts_pkg::DWELL_W-1:0] den,
    output dts_pkg::div_res_t           res
);
    import dts_pkg::*;

    logic [DWELL_W-1:0]   rem_reg;
    logic [PROG_W-1:0]    quot_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DWELL_W:0]     sh;
    logic [DWELL_W+1:0]   trial;
    logic                 ge;

    // num <= den, so the top quotient bit is set only when they match
    assign sh    = {rem_reg, 1'b0};
    assign trial = {1'b0, sh} - {2'b00, den};
    assign ge    = !trial[DWELL_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= {{(PROG_W-1){1'b0}}, num == den};
            rem_reg  <= (num == den) ? '0 : num;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[PROG_W-2:0], ge};
            rem_reg  <= ge ? trial[DWELL_W-1:0] : sh[DWELL_W-1:0];
        end
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;

endmodule

// ----- sv/dwell_time_selection_trigger.sv -----
// Top level: selection tracking, dwell evaluation sequencer and output register.
// Sequence: a rearm word, or a frame word that needs no timing, goes from IDLE
//   straight to FIN; with timing, the serial subtract runs first (SUB), and the
//   progress division (DIV, one quotient bit per cycle) follows when it is needed.
// Flow: one word at a time; a new word is accepted once the previous result
//   sits in the output register, which FIN loads only when the output is free.
// Reset: asynchronous, trigger open, dwell time 600 ms.
module dwell_time_selection_trigger (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         kind,
    input  logic [dts_pkg::TS_W-1:0]     now_ms,
    input  logic                         cell_valid,
    input  logic [dts_pkg::CELL_W-1:0]   cell_row,
    input  logic [dts_pkg::CELL_W-1:0]   cell_col,
    input  logic                         over_button,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [dts_pkg::MODE_W-1:0]   trigger_state,
    output logic [dts_pkg::PROG_W-1:0]   progress,
    output logic                         progress_written,
    input  logic                         cfg_we,
    input  logic [dts_pkg::DWELL_W-1:0]  cfg_wdata
);
    import dts_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUB  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;

    localparam logic [CELL_W:0] GRID_LIM = (CELL_W+1)'(GRID_DIM);

    logic [2:0]         state_reg, state_next;
    logic [DWELL_W-1:0] dwell_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic               last_valid_reg;
    logic [CELL_W-1:0]  last_row_reg;
    logic [CELL_W-1:0]  last_col_reg;
    logic [TS_W-1:0]    cell_entry_reg;
    logic               btn_focused_reg;
    logic [TS_W-1:0]    btn_since_reg;
    logic [PROG_W-1:0]  res_prog_reg;
    logic               res_wr_reg;
    logic               out_valid_reg;
    logic [MODE_W-1:0]  out_state_reg;
    logic [PROG_W-1:0]  out_prog_reg;
    logic               out_wr_reg;

    logic               accept;
    logic               sel_valid;
    logic               same;
    logic               need_eval;
    logic [TS_W-1:0]    eval_ref;
    logic               sub_start;
    logic               div_start;
    logic               out_free;
    logic               gt_dwell;
    logic               gt_half;
    logic               zero_el;
    sub_res_t           sub_res;
    div_res_t           div_res;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign sel_valid = cell_valid && ({1'b0, cell_row} < GRID_LIM)
                       && ({1'b0, cell_col} < GRID_LIM);
    assign same      = last_valid_reg && sel_valid && (cell_row == last_row_reg)
                       && (cell_col == last_col_reg);
    assign need_eval = over_button || (same && (mode_reg != MODE_HOLD));
    assign eval_ref  = over_button ? (btn_focused_reg ? btn_since_reg : now_ms)
                                   : cell_entry_reg;
    assign sub_start = accept && (kind == KIND_FRAME) && need_eval;

    assign gt_dwell  = sub_res.diff > {{(TS_W-DWELL_W){1'b0}}, dwell_reg};
    assign gt_half   = {sub_res.diff[DWELL_W-1:0], 1'b0} > {1'b0, dwell_reg};
    assign zero_el   = (sub_res.diff[DWELL_W-1:0] == '0);
    assign div_start = (state_reg == S_SUB) && sub_res.done && !gt_dwell && !zero_el;

    dts_ser_sub u_sub (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sub_start),
        .a     (now_ms),
        .b     (eval_ref),
        .res   (sub_res)
    );

    dts_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sub_res.diff[DWELL_W-1:0]),
        .den   (dwell_reg),
        .res   (div_res)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = sub_start ? S_SUB : S_FIN;
            end
            S_SUB:
            begin
                if (sub_res.done)
                    state_next = div_start ? S_DIV : S_FIN;
            end
            S_DIV:
            begin
                if (div_res.done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            dwell_reg       <= DWELL_RESET;
            mode_reg        <= MODE_OPEN;
            last_valid_reg  <= 1'b0;
            last_row_reg    <= '0;
            last_col_reg    <= '0;
            cell_entry_reg  <= '0;
            btn_focused_reg <= 1'b0;
            btn_since_reg   <= '0;
            res_prog_reg    <= '0;
            res_wr_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                dwell_reg <= cfg_wdata;

            if (accept)
            begin
                res_prog_reg <= PROG_ZERO;
                if (kind == KIND_REARM)
                begin
                    mode_reg       <= MODE_HOLD;
                    cell_entry_reg <= now_ms;
                    res_wr_reg     <= 1'b0;
                end
                else
                begin
                    last_valid_reg <= sel_valid;
                    if (sel_valid)
                    begin
                        last_row_reg <= cell_row;
                        last_col_reg <= cell_col;
                    end
                    if (!same && sel_valid)
                        cell_entry_reg <= now_ms;
                    if (over_button || !same)
                        mode_reg <= MODE_OPEN;
                    res_wr_reg <= over_button || !same || (mode_reg != MODE_HOLD);
                    if (over_button)
                    begin
                        btn_focused_reg <= 1'b1;
                        if (!btn_focused_reg)
                            btn_since_reg <= now_ms;
                    end
                    else
                    begin
                        btn_focused_reg <= 1'b0;
                        btn_since_reg   <= now_ms;
                    end
                end
            end

            if ((state_reg == S_SUB) && sub_res.done)
            begin
                if (gt_dwell)
                begin
                    mode_reg     <= MODE_RELEASED;
                    res_prog_reg <= PROG_FULL;
                end
                else if (gt_half)
                    mode_reg <= MODE_PRESSED;
            end

            if ((state_reg == S_DIV) && div_res.done)
                res_prog_reg <= div_res.quot;

            if ((state_reg == S_FIN) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_FIN) && out_free)
        begin
            out_state_reg <= mode_reg;
            out_prog_reg  <= res_prog_reg;
            out_wr_reg    <= res_wr_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign trigger_state    = out_state_reg;
    assign progress         = out_prog_reg;
    assign progress_written = out_wr_reg;

    a_prog_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> progress <= PROG_FULL)
        else $error("progress above full scale");

    a_unwritten_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !progress_written) |-> progress == PROG_ZERO)
        else $error("unwritten progress not zero");

    a_hold_unwritten: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && trigger_state == MODE_HOLD) |-> !progress_written)
        else $error("hold word carries progress");

    a_sub_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        sub_res.done |-> state_reg == S_SUB)
        else $error("subtractor finished outside timing phase");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> state_reg == S_DIV)
        else $error("divider finished outside division phase");

endmodule
